// ----- sv/lmrs_pkg.sv -----
// Shared constants, types and address helpers for the LED matrix row scan unit.
// No dependencies.
package lmrs_pkg;

  localparam int ROWS          = 32;
  localparam int BYTES_PER_ROW = 8;
  localparam int STORE_DEPTH   = ROWS * BYTES_PER_ROW;
  localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // fixed field widths
  localparam int ROW_W  = 5;
  localparam int WCOL_W = 3;
  localparam int DATA_W = 8;

  // scan column counter
  localparam int COL_W = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef logic [ADDR_W-1:0] store_addr_t;

  typedef struct packed {
    logic              en;
    store_addr_t       addr;
    logic [DATA_W-1:0] data;
  } fs_wr_t;

  typedef struct packed {
    logic        en;
    store_addr_t addr;
  } fs_rd_t;

  function automatic store_addr_t store_addr(input logic [ROW_W-1:0] row, input int col);
    int lin;
    lin = int'(row) * BYTES_PER_ROW + col;
    return ADDR_W'(lin);
  endfunction

  function automatic logic wr_in_range(input logic [ROW_W-1:0]  row,
                                       input logic [WCOL_W-1:0] col);
    return (int'(row) < ROWS) && (int'(col) < BYTES_PER_ROW);
  endfunction

endpackage

// ----- sv/lmrs_frame_store.sv -----
// Frame store: pixel byte memory with registered read, plus per-entry
// valid bits so that never-written entries read as zero after reset. Uses lmrs_pkg.
module lmrs_frame_store
  import lmrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  fs_wr_t            wr,
  input  fs_rd_t            rd,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [DATA_W-1:0] mem_q_r;
  logic              vld_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_q_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

// ----- sv/led_matrix_row_scan_unit.sv -----
// LED matrix row scan unit: a write transfer stores one byte and busy stays
// low. A tick transfer passes through the scan and drain states and emits
// BYTES_PER_ROW results on consecutive cycles, each registered from a frame
// store read issued in the scan state; busy is high in both states, so a new
// transfer is taken only once the row is done. The receiver cannot stall.
// Synchronous reset clears the scan row and marks every frame store entry as zero.
module led_matrix_row_scan_unit
  import lmrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_mode,
  input  logic [ROW_W-1:0]  in_write_row,
  input  logic [WCOL_W-1:0] in_write_column,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  output logic [ROW_W-1:0]  out_row_select,
  output logic [DATA_W-1:0] out_pixel_byte,
  output logic              out_last_of_row
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_t;

  state_t           state_r;
  logic [ROW_W-1:0] scan_row_r;
  logic [COL_W-1:0] col_r;
  logic             rd_vld_r;
  logic             rd_last_r;

  fs_wr_t fs_wr;
  fs_rd_t fs_rd;
  logic   accept;
  logic   col_last;

  assign accept   = start && !busy;
  assign col_last = (col_r == COL_W'(BYTES_PER_ROW - 1));

  always_comb begin
    fs_wr.en   = accept && (in_mode == MODE_WRITE) &&
                 wr_in_range(in_write_row, in_write_column);
    fs_wr.addr = store_addr(in_write_row, int'(in_write_column));
    fs_wr.data = in_write_data;
    fs_rd.en   = (state_r == S_SCAN);
    fs_rd.addr = store_addr(scan_row_r, int'(col_r));
  end

  lmrs_frame_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (fs_wr),
    .rd      (fs_rd),
    .rd_data (out_pixel_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_row_r <= '0;
      col_r      <= '0;
      rd_vld_r   <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      rd_vld_r  <= (state_r == S_SCAN);
      rd_last_r <= (state_r == S_SCAN) && col_last;
      unique case (state_r)
        S_IDLE: begin
          col_r <= '0;
          if (accept && (in_mode == MODE_TICK)) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          col_r <= col_r + COL_W'(1);
          if (col_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last byte is on the outputs this cycle; advance row after it
          state_r <= S_IDLE;
          if (scan_row_r == ROW_W'(ROWS - 1)) begin
            scan_row_r <= '0;
          end else begin
            scan_row_r <= scan_row_r + ROW_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = rd_vld_r;
  assign out_last_of_row = rd_last_r;
  assign out_row_select  = scan_row_r;

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a scan");

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_of_row |-> out_valid)
    else $error("last_of_row without result strobe");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_row) |=> !busy)
    else $error("busy after last result of row");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_row) |=>
      (out_valid && out_row_select == $past(out_row_select)))
    else $error("row run broken or row changed mid run");

endmodule
